/* hw/rtl/sais_pkg.sv */
// Shared types and constants of the suffix array interval search block.
// Depends on nothing; every other file of the block but sais_ram imports it.
`timescale 1ns / 1ps

package sais_pkg;

  localparam int unsigned RowW    = 16;
  localparam int unsigned DepthW  = 17;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned SaW     = 16;
  localparam int unsigned CfgW    = 17;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned PosW    = 18;

  localparam logic [DepthW-1:0] MaxDepth = {DepthW{1'b1}};

  typedef enum logic [1:0] {
    REQ_WR_TEXT = 2'd0,
    REQ_WR_SA   = 2'd1,
    REQ_RESET   = 2'd2,
    REQ_REFINE  = 2'd3
  } req_type_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SA_COUNT    = 1'b0,
    CFG_TEXT_LENGTH = 1'b1
  } cfg_index_e;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_SEARCH,
    CORE_EMIT
  } core_state_e;

  typedef enum logic [2:0] {
    SRCH_IDLE,
    SRCH_RD_TXT,
    SRCH_EVAL,
    SRCH_MID,
    SRCH_DONE
  } srch_state_e;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_LAST,
    PH_LOOP1,
    PH_LOOP2
  } srch_phase_e;

  typedef struct packed {
    logic              go;
    logic [ByteW-1:0]  ch;
    logic [RowW-1:0]   start_row;
    logic [RowW-1:0]   end_row;
    logic [DepthW-1:0] depth;
  } sais_start_t;

  typedef struct packed {
    logic            done;
    logic            found;
    logic [RowW-1:0] lo_row;
    logic [RowW-1:0] hi_row;
  } sais_result_t;

endpackage

/* hw/rtl/sais_if.sv */
// Request and response channel interfaces of the suffix array interval search.
// Depends on sais_pkg for the field widths.
`timescale 1ns / 1ps

interface sais_req_if import sais_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       req_type;
  logic [RowW-1:0]  addr;
  logic [SaW-1:0]   wdata;
  logic [ByteW-1:0] ch;

  modport source (output valid, output req_type, output addr, output wdata, output ch,
                  input ready);
  modport sink   (input valid, input req_type, input addr, input wdata, input ch,
                  output ready);
endinterface

interface sais_rsp_if import sais_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              found;
  logic [RowW-1:0]   lo_row;
  logic [RowW-1:0]   hi_row;
  logic [DepthW-1:0] match_len;

  modport source (output valid, output found, output lo_row, output hi_row,
                  output match_len, input ready);
  modport sink   (input valid, input found, input lo_row, input hi_row,
                  input match_len, output ready);
endinterface

/* hw/rtl/sais_ram.sv */
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module sais_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/sais_search.sv */
// Refine sequencer: probes suffix and text memories to binary-search the new borders.
// Depends on sais_pkg; the memories themselves sit in the top level.
`timescale 1ns / 1ps

module sais_search import sais_pkg::*; #(
  parameter int unsigned TEXT_DEPTH = 65536,
  parameter int unsigned SA_DEPTH   = 65536
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sais_start_t                   start_i,
  input  logic [CfgW-1:0]               text_length_i,
  input  logic [SaW-1:0]                sa_rdata_i,
  input  logic [ByteW-1:0]              text_rdata_i,
  output logic [$clog2(SA_DEPTH)-1:0]   sa_raddr_o,
  output logic [$clog2(TEXT_DEPTH)-1:0] text_raddr_o,
  output sais_result_t                  result_o
);

  localparam int unsigned TextAw = $clog2(TEXT_DEPTH);
  localparam int unsigned SaAw   = $clog2(SA_DEPTH);
  localparam logic [31:0] TextDepthW = 32'(TEXT_DEPTH);
  localparam logic [31:0] SaDepthW   = 32'(SA_DEPTH);

  srch_state_e state_q, state_d;
  srch_phase_e phase_q, phase_d;

  logic [ByteW-1:0]  c_q, c_d;
  logic [DepthW-1:0] depth_q, depth_d;
  logic [RowW-1:0]   start_q, start_d, end_q, end_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [RowW-1:0]   l_q, l_d, r_q, r_d, r2_q, r2_d;
  logic signed [RowW+1:0] l2_q, l2_d;
  logic hit_q, hit_d, miss_q, miss_d, firsteq_q, firsteq_d, lasteq_q, lasteq_d;
  logic txt_oob_q, txt_oob_d;

  // Probe datapath: suffix start plus depth gives the text position.
  logic            row_oob;
  logic [SaW-1:0]  sa_val;
  logic [PosW-1:0] pos;
  logic [31:0]     pos32, row32;
  logic [ByteW-1:0] byte_val;
  logic            c_lt_b, c_eq_b;

  assign row_oob  = {16'd0, row_q} >= SaDepthW;
  assign sa_val   = row_oob ? '0 : sa_rdata_i;
  assign pos      = PosW'(sa_val) + PosW'(depth_q);
  assign pos32    = 32'(pos);
  assign txt_oob_d = (CfgW'(pos) >= text_length_i) || pos[PosW-1] || (pos32 >= TextDepthW);
  assign text_raddr_o = pos32[TextAw-1:0];
  assign row32    = 32'(row_d);
  assign sa_raddr_o = row32[SaAw-1:0];

  assign byte_val = txt_oob_q ? '0 : text_rdata_i;
  assign c_lt_b   = c_q < byte_val;
  assign c_eq_b   = c_q == byte_val;

  // Lower border search step.
  logic [RowW-1:0] l_n, r_n, lp_l, lp_r, m1;
  logic [RowW:0]   sum1;
  logic            cont1;

  assign l_n   = (c_lt_b || c_eq_b) ? l_q : row_q;
  assign r_n   = (c_lt_b || c_eq_b) ? row_q : r_q;
  assign lp_l  = (phase_q == PH_LOOP1) ? l_n : start_q;
  assign lp_r  = (phase_q == PH_LOOP1) ? r_n : end_q;
  assign sum1  = (RowW+1)'(lp_l) + (RowW+1)'(lp_r);
  assign m1    = sum1[RowW:1];
  assign cont1 = (RowW+1)'(lp_r) > ((RowW+1)'(lp_l) + 1'b1);

  // Upper border search step.
  logic signed [RowW+1:0] l2_eff, l2_n, l2_src, r2_src, sum2;
  logic [RowW-1:0]        m2;
  logic                   cont2;

  assign l2_eff = hit_q ? l2_q : ($signed({2'b00, l_q}) - 18'sd1);
  assign l2_n   = c_lt_b ? l2_q : $signed({2'b00, row_q});
  assign l2_src = (state_q == SRCH_MID) ? l2_eff : l2_n;
  assign r2_src = (state_q == SRCH_MID) ? $signed({2'b00, r2_q})
                                        : $signed({2'b00, (c_lt_b ? row_q : r2_q)});
  assign sum2   = l2_src + r2_src;
  assign m2     = sum2[RowW:1];
  assign cont2  = r2_src > (l2_src + 18'sd1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SRCH_IDLE: begin
        if (start_i.go) begin
          state_d = (start_i.start_row > start_i.end_row) ? SRCH_DONE : SRCH_RD_TXT;
        end
      end
      SRCH_RD_TXT: state_d = SRCH_EVAL;
      SRCH_EVAL: begin
        unique case (phase_q)
          PH_FIRST: state_d = c_lt_b ? SRCH_DONE : SRCH_RD_TXT;
          PH_LAST: begin
            if (!c_lt_b && !c_eq_b) begin
              state_d = SRCH_DONE;
            end else if (firsteq_q || !cont1) begin
              state_d = SRCH_MID;
            end else begin
              state_d = SRCH_RD_TXT;
            end
          end
          PH_LOOP1: state_d = cont1 ? SRCH_RD_TXT : SRCH_MID;
          PH_LOOP2: state_d = cont2 ? SRCH_RD_TXT : SRCH_DONE;
          default:  state_d = SRCH_DONE;
        endcase
      end
      SRCH_MID:  state_d = (!lasteq_q && cont2) ? SRCH_RD_TXT : SRCH_DONE;
      SRCH_DONE: state_d = SRCH_IDLE;
      default:   state_d = SRCH_IDLE;
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    c_d       = c_q;
    depth_d   = depth_q;
    start_d   = start_q;
    end_d     = end_q;
    row_d     = row_q;
    l_d       = l_q;
    r_d       = r_q;
    l2_d      = l2_q;
    r2_d      = r2_q;
    hit_d     = hit_q;
    miss_d    = miss_q;
    firsteq_d = firsteq_q;
    lasteq_d  = lasteq_q;
    case (state_q)
      SRCH_IDLE: begin
        if (start_i.go) begin
          c_d     = start_i.ch;
          depth_d = start_i.depth;
          start_d = start_i.start_row;
          end_d   = start_i.end_row;
          row_d   = start_i.start_row;
          phase_d = PH_FIRST;
          hit_d   = 1'b0;
          miss_d  = start_i.start_row > start_i.end_row;
        end
      end
      SRCH_EVAL: begin
        case (phase_q)
          PH_FIRST: begin
            miss_d    = c_lt_b;
            firsteq_d = c_eq_b;
            row_d     = end_q;
            phase_d   = PH_LAST;
          end
          PH_LAST: begin
            miss_d   = !c_lt_b && !c_eq_b;
            lasteq_d = c_eq_b;
            l_d      = start_q;
            r_d      = end_q;
            l2_d     = $signed({2'b00, start_q});
            r2_d     = end_q;
            hit_d    = firsteq_q;
            if (!firsteq_q) begin
              if (cont1) begin
                row_d   = m1;
                phase_d = PH_LOOP1;
              end else begin
                l_d = end_q;
              end
            end
          end
          PH_LOOP1: begin
            if (c_lt_b || c_eq_b) begin
              if (!hit_q && c_eq_b) begin
                hit_d = 1'b1;
                l2_d  = $signed({2'b00, row_q});
                r2_d  = r_q;
              end
            end
            l_d   = cont1 ? l_n : r_n;
            r_d   = r_n;
            row_d = m1;
          end
          default: begin
            l2_d  = l2_n;
            r2_d  = r2_src[RowW-1:0];
            row_d = m2;
          end
        endcase
      end
      SRCH_MID: begin
        l2_d    = lasteq_q ? $signed({2'b00, end_q}) : l2_eff;
        row_d   = m2;
        phase_d = PH_LOOP2;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result_o.done   = state_q == SRCH_DONE;
    result_o.found  = !miss_q && !($signed({2'b00, l_q}) > l2_q);
    result_o.lo_row = l_q;
    result_o.hi_row = l2_q[RowW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SRCH_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q   <= phase_d;
    c_q       <= c_d;
    depth_q   <= depth_d;
    start_q   <= start_d;
    end_q     <= end_d;
    row_q     <= row_d;
    l_q       <= l_d;
    r_q       <= r_d;
    l2_q      <= l2_d;
    r2_q      <= r2_d;
    hit_q     <= hit_d;
    miss_q    <= miss_d;
    firsteq_q <= firsteq_d;
    lasteq_q  <= lasteq_d;
    txt_oob_q <= txt_oob_d;
  end

endmodule

/* hw/rtl/suffix_array_interval_search_core.sv */
// Top level of the suffix array interval search: channels, configuration, interval state.
// Depends on sais_pkg, sais_if, sais_ram and sais_search.
`timescale 1ns / 1ps

// The block keeps a text store and a suffix array store in two single-port RAMs, both
// loaded through write requests, plus the current search interval and match depth.
// Requests are handled one at a time. A write or interval reset request goes from idle
// straight to the emit state, which loads the response register. A refine request runs a
// probe sequencer in which every probe reads the suffix RAM and then the text RAM at
// that suffix start plus the match depth. It probes both ends of the interval, then
// binary-searches the lower and the upper border; each search takes at most 16 probes
// for a full 65536-row interval. A new request is accepted whenever the block is idle,
// even while the previous response still waits in the output register. The stores come
// up undefined and are never cleared, so there is no initialization pass after reset.
// Configuration registers (index 0 sa_count, index 1 text_length) should only be written
// while idle.
module suffix_array_interval_search_core import sais_pkg::*; #(
  parameter int unsigned TEXT_DEPTH = 65536,
  parameter int unsigned SA_DEPTH   = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  sais_req_if.sink           req_i,
  sais_rsp_if.source         rsp_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  localparam int unsigned TextAw = $clog2(TEXT_DEPTH);
  localparam int unsigned SaAw   = $clog2(SA_DEPTH);
  localparam logic [31:0] TextDepthW = 32'(TEXT_DEPTH);
  localparam logic [31:0] SaDepthW   = 32'(SA_DEPTH);

  core_state_e state_q, state_d;

  // Configuration registers.
  logic [CfgW-1:0] sa_count_q, text_length_q;

  // Interval state and the result of the request in flight.
  logic [RowW-1:0]   ivl_start_q, ivl_end_q;
  logic [DepthW-1:0] depth_q;
  logic              found_q;

  // Response register.
  logic              rsp_valid_q;
  logic              rsp_found_q;
  logic [RowW-1:0]   rsp_lo_q, rsp_hi_q;
  logic [DepthW-1:0] rsp_len_q;

  logic      req_acc;
  logic      out_load;
  req_type_e req_type;

  assign req_type = req_type_e'(req_i.req_type);
  assign req_acc  = req_i.valid && req_i.ready;

  // A write to an address past the end of a store is dropped but still answered.
  logic [31:0] addr32;
  logic        text_we, sa_we;

  assign addr32  = 32'(req_i.addr);
  assign text_we = req_acc && (req_type == REQ_WR_TEXT) && (addr32 < TextDepthW);
  assign sa_we   = req_acc && (req_type == REQ_WR_SA) && (addr32 < SaDepthW);

  // Full interval end row, clipped to the 16-bit row range.
  logic [RowW-1:0] full_end;
  logic [CfgW-1:0] count_m1;

  assign count_m1 = sa_count_q - 1'b1;
  always_comb begin
    if (sa_count_q == '0) begin
      full_end = '0;
    end else if (sa_count_q[CfgW-1]) begin
      full_end = {RowW{1'b1}};
    end else begin
      full_end = count_m1[RowW-1:0];
    end
  end

  // Search sequencer and the two stores it reads.
  sais_start_t            srch_start;
  sais_result_t           srch_result;
  logic [SaAw-1:0]        srch_sa_addr, sa_addr;
  logic [TextAw-1:0]      srch_text_addr, text_addr;
  logic [SaW-1:0]         sa_rdata;
  logic [ByteW-1:0]       text_rdata;

  always_comb begin
    srch_start.go        = req_acc && (req_type == REQ_REFINE);
    srch_start.ch        = req_i.ch;
    srch_start.start_row = ivl_start_q;
    srch_start.end_row   = ivl_end_q;
    srch_start.depth     = depth_q;
  end

  // Writes only happen in the cycle a write request is accepted; the sequencer owns the
  // address ports at every other time.
  assign sa_addr   = sa_we ? addr32[SaAw-1:0] : srch_sa_addr;
  assign text_addr = text_we ? addr32[TextAw-1:0] : srch_text_addr;

  sais_search #(
    .TEXT_DEPTH (TEXT_DEPTH),
    .SA_DEPTH   (SA_DEPTH)
  ) u_search (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (srch_start),
    .text_length_i (text_length_q),
    .sa_rdata_i    (sa_rdata),
    .text_rdata_i  (text_rdata),
    .sa_raddr_o    (srch_sa_addr),
    .text_raddr_o  (srch_text_addr),
    .result_o      (srch_result)
  );

  sais_ram #(
    .WIDTH (SaW),
    .DEPTH (SA_DEPTH)
  ) u_sa_ram (
    .clk_i   (clk_i),
    .we_i    (sa_we),
    .addr_i  (sa_addr),
    .wdata_i (req_i.wdata),
    .rdata_o (sa_rdata)
  );

  sais_ram #(
    .WIDTH (ByteW),
    .DEPTH (TEXT_DEPTH)
  ) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (text_we),
    .addr_i  (text_addr),
    .wdata_i (req_i.wdata[ByteW-1:0]),
    .rdata_o (text_rdata)
  );

  // Next state: a refine waits for the sequencer, everything else goes straight to emit.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CORE_IDLE: begin
        if (req_acc) begin
          state_d = (req_type == REQ_REFINE) ? CORE_SEARCH : CORE_EMIT;
        end
      end
      CORE_SEARCH: begin
        if (srch_result.done) begin
          state_d = CORE_EMIT;
        end
      end
      CORE_EMIT: begin
        if (out_load) begin
          state_d = CORE_IDLE;
        end
      end
      default: state_d = CORE_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    req_i.ready = state_q == CORE_IDLE;
    out_load    = (state_q == CORE_EMIT) && (!rsp_valid_q || rsp_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= CORE_IDLE;
      sa_count_q    <= CfgW'(1);
      text_length_q <= '0;
      ivl_start_q   <= '0;
      ivl_end_q     <= '0;
      depth_q       <= '0;
      rsp_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_index_e'(cfg_index_i))
          CFG_SA_COUNT:    sa_count_q    <= cfg_wdata_i;
          CFG_TEXT_LENGTH: text_length_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end

      if (req_acc && (req_type == REQ_RESET)) begin
        ivl_start_q <= '0;
        ivl_end_q   <= full_end;
        depth_q     <= '0;
      end else if ((state_q == CORE_SEARCH) && srch_result.done && srch_result.found) begin
        ivl_start_q <= srch_result.lo_row;
        ivl_end_q   <= srch_result.hi_row;
        if (depth_q != MaxDepth) begin
          depth_q <= depth_q + 1'b1;
        end
      end

      if (out_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      found_q <= 1'b1;
    end else if ((state_q == CORE_SEARCH) && srch_result.done) begin
      found_q <= srch_result.found;
    end
    if (out_load) begin
      rsp_found_q <= found_q;
      rsp_lo_q    <= ivl_start_q;
      rsp_hi_q    <= ivl_end_q;
      rsp_len_q   <= depth_q;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.found     = rsp_found_q;
  assign rsp_o.lo_row    = rsp_lo_q;
  assign rsp_o.hi_row    = rsp_hi_q;
  assign rsp_o.match_len = rsp_len_q;

  // The sequencer only finishes while the top level waits for it.
  a_done_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    srch_result.done |-> state_q == CORE_SEARCH)
    else $error("search finished outside of a refine");

  // An accepted refine always hands over to the sequencer.
  a_refine_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && req_type == REQ_REFINE) |=> state_q == CORE_SEARCH)
    else $error("refine request did not start a search");

  // The match depth only returns to zero or steps up by one.
  a_depth_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (depth_q != $past(depth_q)) |-> (depth_q == '0 || depth_q == $past(depth_q) + 1'b1))
    else $error("match depth changed by more than one");

  // A response only appears after the emit state.
  a_rsp_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q) == CORE_EMIT)
    else $error("response loaded outside of emit");

endmodule

/* tb/suffix_array_interval_search_core_test.sv */
// Self-checking test of the suffix array interval search core: interval tracker plus stimulus.
// Depends on sais_pkg, sais_if and the RTL of suffix_array_interval_search_core.
`timescale 1ns / 1ps

import sais_pkg::*;

// Mirrors both stores, the interval and the two limit registers, and keeps the queue of
// interval responses that the core still owes.
class interval_tracker;
  localparam int unsigned StoreDepth = 65536;

  typedef struct packed {
    logic              found;
    logic [RowW-1:0]   lo_row;
    logic [RowW-1:0]   hi_row;
    logic [DepthW-1:0] match_len;
  } interval_t;

  bit [ByteW-1:0]    text_store [StoreDepth];
  bit                text_known [StoreDepth];
  bit [SaW-1:0]      suffix_store [StoreDepth];
  bit                suffix_known [StoreDepth];
  logic [RowW-1:0]   lo_q = '0;
  logic [RowW-1:0]   hi_q = '0;
  logic [DepthW-1:0] depth_q = '0;
  logic [CfgW-1:0]   sa_count_q = 17'd1;
  logic [CfgW-1:0]   text_len_q = '0;
  interval_t         expected_intervals [$];
  int                failures;

  // First store entry that a search touched before anything was written there.
  bit     gap_seen;
  bit     gap_in_text;
  longint gap_addr;

  function void note_gap(bit in_text, longint where);
    if (!gap_seen) begin
      gap_seen    = 1'b1;
      gap_in_text = in_text;
      gap_addr    = where;
    end
  endfunction

  function void set_register(cfg_index_e idx, logic [CfgW-1:0] value);
    if (idx == CFG_SA_COUNT) sa_count_q = value;
    else text_len_q = value;
  endfunction

  // Text byte at the current depth below the suffix that a row points to.
  function int row_byte(longint row);
    longint pos;
    if (!suffix_known[row]) note_gap(1'b0, row);
    pos = longint'(suffix_store[row]) + longint'(depth_q);
    if (pos >= longint'(text_len_q) || pos >= StoreDepth) return 0;
    if (!text_known[pos]) note_gap(1'b1, pos);
    return int'(text_store[pos]);
  endfunction

  // Lower and upper border of the rows whose byte at the current depth equals c.
  function bit find_borders(int c, longint row_a, longint row_b,
                            output longint new_lo, output longint new_hi);
    longint l, r, m, l2, r2;
    int d, d_head, d_tail;
    bit hit;
    l2 = row_a;
    r2 = row_b;
    hit = 1'b0;
    new_lo = 0;
    new_hi = 0;
    d_head = c - row_byte(row_a);
    d_tail = c - row_byte(row_b);
    if (row_a > row_b || d_head < 0 || d_tail > 0) return 1'b0;
    l = row_a;
    r = row_b;
    if (d_head == 0) begin
      hit = 1'b1;
      r2 = r;
    end else begin
      while (r > l + 1) begin
        m = (l + r) / 2;
        d = c - row_byte(m);
        if (d <= 0) begin
          if (!hit && d == 0) begin
            hit = 1'b1;
            l2 = m;
            r2 = r;
          end
          r = m;
        end else begin
          l = m;
        end
      end
      l = r;
    end
    if (!hit) l2 = l - 1;
    if (d_tail == 0) begin
      l2 = row_b;
    end else begin
      while (r2 > l2 + 1) begin
        m = (l2 + r2) / 2;
        d = c - row_byte(m);
        if (d < 0) r2 = m;
        else l2 = m;
      end
    end
    if (l > l2) return 1'b0;
    new_lo = l;
    new_hi = l2;
    return 1'b1;
  endfunction

  function void note_request(req_type_e kind, logic [RowW-1:0] addr,
                             logic [SaW-1:0] wdata, logic [ByteW-1:0] ch);
    interval_t e;
    longint lo, hi;
    logic [CfgW-1:0] rows;
    e.found = 1'b1;
    case (kind)
      REQ_WR_TEXT: begin
        text_store[addr] = wdata[ByteW-1:0];
        text_known[addr] = 1'b1;
      end
      REQ_WR_SA: begin
        suffix_store[addr] = wdata;
        suffix_known[addr] = 1'b1;
      end
      REQ_RESET: begin
        rows = (sa_count_q > 17'h10000) ? 17'h10000 : sa_count_q;
        lo_q = '0;
        hi_q = (rows == 0) ? '0 : RowW'(rows - 1);
        depth_q = '0;
      end
      default: begin
        if (find_borders(int'(ch), longint'(lo_q), longint'(hi_q), lo, hi)) begin
          lo_q = RowW'(lo);
          hi_q = RowW'(hi);
          if (depth_q != MaxDepth) depth_q = depth_q + 1'b1;
        end else begin
          e.found = 1'b0;
        end
      end
    endcase
    e.lo_row    = lo_q;
    e.hi_row    = hi_q;
    e.match_len = depth_q;
    expected_intervals.push_back(e);
  endfunction

  function void check_response(logic found, logic [RowW-1:0] lo_row,
                               logic [RowW-1:0] hi_row, logic [DepthW-1:0] match_len);
    interval_t e;
    if (expected_intervals.size() == 0) begin
      $error("response arrived with no request outstanding");
      failures++;
      return;
    end
    e = expected_intervals.pop_front();
    if (found !== e.found) begin
      $error("found: expected %0d, actual %0d", e.found, found);
      failures++;
    end
    if (lo_row !== e.lo_row) begin
      $error("lo_row: expected %0d, actual %0d", e.lo_row, lo_row);
      failures++;
    end
    if (hi_row !== e.hi_row) begin
      $error("hi_row: expected %0d, actual %0d", e.hi_row, hi_row);
      failures++;
    end
    if (match_len !== e.match_len) begin
      $error("match_len: expected %0d, actual %0d", e.match_len, match_len);
      failures++;
    end
  endfunction
endclass

module suffix_array_interval_search_core_test;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  cfg_index_e       cfg_index;
  logic [CfgW-1:0]  cfg_wdata;

  // When set, neither side idles: the request side presents back to back and the
  // response side is always ready.
  logic             calm;

  int               reqs_sent;
  // Upper bound for suffix start values that fill-in writes put into unwritten rows.
  int               fill_span;

  // Text of the current phase and its suffixes in sorted order.
  logic [7:0]       phase_text [$];
  int               suffix_order [$];

  interval_tracker  tracker = new();

  sais_req_if req_ch ();
  sais_rsp_if rsp_ch ();

  suffix_array_interval_search_core #(
    .TEXT_DEPTH(65536),
    .SA_DEPTH  (65536)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // The response side stalls on its own schedule, independent of the request side.
  always @(posedge clk_i) begin
    rsp_ch.ready <= calm || ($urandom_range(99) >= 36);
  end

  // Every handshake on the response channel is checked against the oldest expectation.
  // Values are read at the edge, before any nonblocking update of that edge lands.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      tracker.check_response(rsp_ch.found, rsp_ch.lo_row, rsp_ch.hi_row, rsp_ch.match_len);
    end
  end

  // Presents one request and returns at the edge that accepts it. Valid is left high, so
  // a following request goes out back to back; whoever comes next lowers it if needed.
  // The tracker is updated here rather than in a monitor so that the stimulus code that
  // runs next at the same edge already sees the state after this request.
  task automatic send_request(req_type_e kind, logic [RowW-1:0] addr,
                              logic [SaW-1:0] wdata, logic [ByteW-1:0] ch);
    while (!calm && $urandom_range(99) < 36) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.addr     <= addr;
    req_ch.wdata    <= wdata;
    req_ch.ch       <= ch;
    do @(posedge clk_i); while (!req_ch.ready);
    tracker.note_request(kind, addr, wdata, ch);
    reqs_sent++;
  endtask

  // Holds the request side off until every owed response has come back.
  task automatic wait_results();
    req_ch.valid <= 1'b0;
    while (tracker.expected_intervals.size() != 0) @(posedge clk_i);
  endtask

  // Writes both limit registers, one after the other; only called while idle.
  task automatic program_limits(logic [CfgW-1:0] sa_rows, logic [CfgW-1:0] text_bytes);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SA_COUNT;
    cfg_wdata <= sa_rows;
    @(posedge clk_i);
    tracker.set_register(CFG_SA_COUNT, sa_rows);
    cfg_index <= CFG_TEXT_LENGTH;
    cfg_wdata <= text_bytes;
    @(posedge clk_i);
    tracker.set_register(CFG_TEXT_LENGTH, text_bytes);
    cfg_we <= 1'b0;
  endtask

  // A refine must never make the core read a store entry that was never written. The
  // search is first run on the tracker alone; each unwritten entry it would touch is
  // written with random content first, and the dry run is repeated until it is clean.
  task automatic refine_char(logic [ByteW-1:0] c);
    longint lo, hi;
    bit     holes;
    holes = 1'b1;
    while (holes) begin
      tracker.gap_seen = 1'b0;
      void'(tracker.find_borders(int'(c), longint'(tracker.lo_q), longint'(tracker.hi_q),
                                 lo, hi));
      holes = tracker.gap_seen;
      if (holes) begin
        if (tracker.gap_in_text) begin
          send_request(REQ_WR_TEXT, RowW'(tracker.gap_addr), SaW'($urandom_range(65535)),
                       ByteW'($urandom_range(255)));
        end else begin
          send_request(REQ_WR_SA, RowW'(tracker.gap_addr), SaW'($urandom_range(fill_span)),
                       ByteW'($urandom_range(255)));
        end
      end
    end
    send_request(REQ_REFINE, RowW'($urandom_range(65535)), SaW'($urandom_range(65535)), c);
  endtask

  // One request of any kind with random content in every field; a refine may be preceded by fill-in writes.
  task automatic send_noise();
    case ($urandom_range(3))
      0: send_request(REQ_WR_TEXT, RowW'($urandom_range(65535)), SaW'($urandom_range(65535)),
                      ByteW'($urandom_range(255)));
      1: send_request(REQ_WR_SA, RowW'($urandom_range(65535)), SaW'($urandom_range(65535)),
                      ByteW'($urandom_range(255)));
      2: send_request(REQ_RESET, RowW'($urandom_range(65535)), SaW'($urandom_range(65535)),
                      ByteW'($urandom_range(255)));
      default: refine_char(ByteW'($urandom_range(255)));
    endcase
  endtask

  // Suffix order where running off the end of the text sorts before any byte.
  function automatic bit suffix_before(int a, int b);
    int k, ca, cb, len;
    len = phase_text.size();
    k = 0;
    while (1) begin
      ca = (a + k < len) ? int'(phase_text[a + k]) : -1;
      cb = (b + k < len) ? int'(phase_text[b + k]) : -1;
      if (ca != cb) return ca < cb;
      k++;
    end
  endfunction

  // A well-formed phase: a short text over a small alphabet, its real suffix array, then
  // pattern searches that mostly follow substrings of the text, so that most refines hit
  // and the interval narrows over several steps. The limits sometimes disagree with
  // what was loaded, which brings text-beyond-length reads and extra rows into play.
  task automatic run_text_phase();
    int len, alpha, base, tl, sc, start, plen, key, j;
    logic [ByteW-1:0] c;
    len = $urandom_range(4, 48);
    alpha = $urandom_range(1, 5);
    case ($urandom_range(3))
      0: base = 0;
      1: base = 256 - alpha;
      default: base = $urandom_range(256 - alpha);
    endcase
    phase_text.delete();
    suffix_order.delete();
    for (int i = 0; i < len; i++) begin
      phase_text.push_back(ByteW'(base + $urandom_range(alpha - 1)));
      suffix_order.push_back(i);
    end
    case ($urandom_range(19))
      0, 1, 2: tl = $urandom_range(len);
      3, 4:    tl = len + $urandom_range(1, 40);
      default: tl = len;
    endcase
    sc = ($urandom_range(3) == 0) ? $urandom_range(1, len + 6) : len;

    wait_results();
    program_limits(CfgW'(sc), CfgW'(tl));
    fill_span = len + 4;

    for (int i = 0; i < len; i++) begin
      send_request(REQ_WR_TEXT, RowW'(i), {8'($urandom_range(255)), phase_text[i]},
                   ByteW'($urandom_range(255)));
    end
    for (int i = 1; i < len; i++) begin
      key = suffix_order[i];
      j = i - 1;
      while (j >= 0 && suffix_before(key, suffix_order[j])) begin
        suffix_order[j + 1] = suffix_order[j];
        j--;
      end
      suffix_order[j + 1] = key;
    end
    for (int i = 0; i < len; i++) begin
      send_request(REQ_WR_SA, RowW'(i), SaW'(suffix_order[i]), ByteW'($urandom_range(255)));
    end

    repeat ($urandom_range(6, 12)) begin
      start = $urandom_range(len - 1);
      plen = $urandom_range(1, 8);
      send_request(REQ_RESET, RowW'($urandom_range(65535)), SaW'($urandom_range(65535)),
                   ByteW'($urandom_range(255)));
      for (int k = 0; k < plen; k++) begin
        c = (start + k < len) ? phase_text[start + k] : 8'h00;
        if ($urandom_range(9) == 0) c = ByteW'($urandom_range(255));
        refine_char(c);
        if ($urandom_range(14) == 0) send_noise();
      end
    end
  endtask

  // Limits given by the caller, often at or beyond their extremes, over whatever the stores hold;
  // unwritten rows and bytes that the searches reach are filled with random values on the way.
  task automatic run_wide_phase(logic [CfgW-1:0] sa_rows, logic [CfgW-1:0] text_bytes);
    wait_results();
    program_limits(sa_rows, text_bytes);
    fill_span = 65535;
    repeat (2) begin
      send_request(REQ_RESET, RowW'($urandom_range(65535)), SaW'($urandom_range(65535)),
                   ByteW'($urandom_range(255)));
      repeat ($urandom_range(1, 3)) begin
        refine_char(($urandom_range(1) == 0) ? 8'h00 : ByteW'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    int item_goal;
    int phase_no;
    logic [CfgW-1:0] wide_sa, wide_tl;

    rst_ni          <= 1'b0;
    calm            <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_SA_COUNT;
    cfg_wdata       <= '0;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_WR_TEXT;
    req_ch.addr     <= '0;
    req_ch.wdata    <= '0;
    req_ch.ch       <= '0;
    reqs_sent = 0;
    fill_span = 65535;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset limits (one row, empty text). Row 0 points at the last
    // text position, and a text write carries junk in the upper data byte.
    send_request(REQ_WR_SA, 16'h0000, 16'hFFFF, 8'h00);
    send_request(REQ_WR_TEXT, 16'hFFFF, 16'hFFA5, 8'hFF);
    send_request(REQ_WR_TEXT, 16'h0000, 16'h5A00, 8'h00);
    // With no valid text every byte reads as zero: a zero hits, anything else misses.
    refine_char(8'h00);
    refine_char(8'hFF);
    send_request(REQ_RESET, 16'hFFFF, 16'h0000, 8'hFF);

    // A zero row count still gives a one-row interval. The text length lies beyond the
    // store, so the last byte is readable while one step deeper runs off the store.
    wait_results();
    program_limits(17'd0, 17'h1FFFF);
    send_request(REQ_RESET, 16'h0000, 16'hFFFF, 8'h00);
    refine_char(8'hA5);
    refine_char(8'h00);
    refine_char(8'h00);

    // Row counts above the store clamp to the last row; the full store is searched.
    run_wide_phase(17'h1FFFF, 17'h10000);
    run_wide_phase(17'h10000, 17'h00000);

    item_goal = reqs_sent + 1250;
    phase_no = 0;
    while (reqs_sent < item_goal) begin
      calm <= (phase_no >= 3 && phase_no <= 5);
      if ($urandom_range(5) == 0) begin
        case ($urandom_range(5))
          0: wide_sa = 17'd0;
          1: wide_sa = 17'd1;
          2: wide_sa = 17'd2;
          3: wide_sa = 17'h10000;
          4: wide_sa = 17'h1FFFF;
          default: wide_sa = CfgW'($urandom_range(17'h1FFFF));
        endcase
        case ($urandom_range(4))
          0: wide_tl = 17'd0;
          1: wide_tl = 17'd1;
          2: wide_tl = 17'h10000;
          3: wide_tl = 17'h1FFFF;
          default: wide_tl = CfgW'($urandom_range(17'h1FFFF));
        endcase
        run_wide_phase(wide_sa, wide_tl);
      end else begin
        run_text_phase();
      end
      phase_no++;
    end

    // The final quiet wait lets any extra response that the core might still produce show up
    // before the verdict.
    wait_results();
    repeat (100) @(posedge clk_i);
    if (tracker.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: ends the run as a mismatch after 20 ms.
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/sais_pkg.sv
hw/rtl/sais_if.sv
hw/rtl/sais_ram.sv
hw/rtl/sais_search.sv
hw/rtl/suffix_array_interval_search_core.sv
tb/suffix_array_interval_search_core_test.sv
